/* hw/rtl/stepgen_pkg.sv */
package stepgen_pkg;

   localparam int NUM_AXES          = 2;
   localparam int AXIS_HOR          = 0;
   localparam int AXIS_VER          = 1;
   localparam int COUNT_WIDTH_DFLT  = 16;

   localparam int POS_WIDTH         = 32;
   localparam int CNT16_WIDTH       = 16;
   localparam int SPU_WIDTH         = 32;
   localparam int CSR_DATA_WIDTH    = 32;
   localparam int CSR_INDEX_WIDTH   = 3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MOVE = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESCALE_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PWM_PERIOD     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PWM_COMPARE    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEPS_PER_UNIT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEAD_BAND      = 3'd4;

   localparam logic [CNT16_WIDTH-1:0] PRESCALE_LIMIT_RST = 16'd0;
   localparam logic [CNT16_WIDTH-1:0] PWM_PERIOD_RST     = 16'd999;
   localparam logic [CNT16_WIDTH-1:0] PWM_COMPARE_RST    = 16'd500;
   localparam logic [SPU_WIDTH-1:0]   STEPS_PER_UNIT_RST = 32'd65536;
   localparam logic [CNT16_WIDTH-1:0] DEAD_BAND_RST      = 16'd66;

   typedef logic [POS_WIDTH-1:0]   pos_type;
   typedef logic [CNT16_WIDTH-1:0] cnt16_type;

endpackage

/* hw/rtl/two_axis_step_dir_pulse_generator.sv */
// Two-axis step/direction pulse generator.
// Input channel req_*: each transaction is either a timer tick (req_op = OP_TICK)
// or a move command (req_op = OP_MOVE) with signed Q16.16 targets for both axes.
// Result channel rsp_*: exactly one result transaction per input transaction,
// carrying the step levels, direction latches, busy flag, move accepted and
// move done flags.
// The result of an accepted transaction is loaded into the output register.
// Throughput: one transaction per cycle while the receiver does not stall; the
// whole state update of an item (distance, 32x32 pulse multiply, prescaler and
// PWM counters) is combinational between acceptance and the result register.
// When the receiver stalls, the result register holds its contents and
// req_stall rises while a result is waiting and rsp_stall is high; as soon as
// the pending result is taken, a new transaction is accepted in the same cycle.
// Configuration registers are written through csr_*; the user must write them
// only while the block is idle, the block does not enforce it; no read-back.
// Reset (synchronous, active high) clears positions, goals, counters and pulse
// counts, loads the register defaults and empties the result register.
module two_axis_step_dir_pulse_generator
   import stepgen_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DFLT
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic signed [POS_WIDTH-1:0] req_hor_target,
   input  logic signed [POS_WIDTH-1:0] req_ver_target,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hor_step,
   output logic                        rsp_ver_step,
   output logic                        rsp_hor_dir,
   output logic                        rsp_ver_dir,
   output logic                        rsp_busy_res,
   output logic                        rsp_move_accepted,
   output logic                        rsp_move_done,

   input  logic                        csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int          PW        = COUNT_WIDTH + 1;
   localparam logic [63:0] PULSE_CAP = 64'd1 << COUNT_WIDTH;

   // configuration
   cnt16_type            prescale_limit_ff;
   cnt16_type            pwm_period_ff;
   cnt16_type            pwm_compare_ff;
   logic [SPU_WIDTH-1:0] steps_per_unit_ff;
   cnt16_type            dead_band_ff;

   // axis state
   pos_type   position_ff [NUM_AXES];
   pos_type   position_in [NUM_AXES];
   pos_type   goal_ff     [NUM_AXES];
   pos_type   goal_in     [NUM_AXES];
   cnt16_type presc_ff    [NUM_AXES];
   cnt16_type presc_in    [NUM_AXES];
   cnt16_type pwm_ff      [NUM_AXES];
   cnt16_type pwm_in      [NUM_AXES];
   logic [PW-1:0] pulses_ff [NUM_AXES];
   logic [PW-1:0] pulses_in [NUM_AXES];
   logic      dir_ff      [NUM_AXES];
   logic      dir_in      [NUM_AXES];

   // move arithmetic
   pos_type      target    [NUM_AXES];
   logic [32:0]  delta     [NUM_AXES];
   logic [32:0]  delta_abs [NUM_AXES];
   pos_type      mag       [NUM_AXES];
   logic [63:0]  prod      [NUM_AXES];
   logic [63:0]  raw_cnt   [NUM_AXES];
   logic [63:0]  sat_cnt   [NUM_AXES];
   logic         in_dead   [NUM_AXES];
   logic [PW-1:0] move_cnt [NUM_AXES];
   logic         step_now  [NUM_AXES];
   logic         step_next [NUM_AXES];

   logic req_accept;
   logic busy_before;
   logic busy_after;
   logic accepted_in;
   logic done_in;

   logic rsp_valid_ff;
   logic rsp_hor_step_ff;
   logic rsp_ver_step_ff;
   logic rsp_hor_dir_ff;
   logic rsp_ver_dir_ff;
   logic rsp_busy_res_ff;
   logic rsp_move_accepted_ff;
   logic rsp_move_done_ff;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign target[AXIS_HOR] = req_hor_target;
   assign target[AXIS_VER] = req_ver_target;

   // pulse count per axis
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         delta[a]     = {target[a][POS_WIDTH-1], target[a]}
                        - {position_ff[a][POS_WIDTH-1], position_ff[a]};
         delta_abs[a] = delta[a][32] ? (33'd0 - delta[a]) : delta[a];
         mag[a]       = delta_abs[a][31:0];
         prod[a]      = mag[a] * steps_per_unit_ff;
         raw_cnt[a]   = {32'd0, prod[a][63:32]};
         sat_cnt[a]   = (raw_cnt[a] > PULSE_CAP) ? PULSE_CAP : raw_cnt[a];
         in_dead[a]   = mag[a] < {16'd0, dead_band_ff};
         move_cnt[a]  = in_dead[a] ? '0 : sat_cnt[a][PW-1:0];
      end
   end

   // next state
   always_comb begin
      busy_before = (pulses_ff[AXIS_HOR] != '0) || (pulses_ff[AXIS_VER] != '0);
      accepted_in = 1'b0;
      done_in     = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         position_in[a] = position_ff[a];
         goal_in[a]     = goal_ff[a];
         presc_in[a]    = presc_ff[a];
         pwm_in[a]      = pwm_ff[a];
         pulses_in[a]   = pulses_ff[a];
         dir_in[a]      = dir_ff[a];
      end
      if (req_op == OP_TICK) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            if (pulses_ff[a] != '0) begin
               if (presc_ff[a] >= prescale_limit_ff) begin
                  presc_in[a] = '0;
                  if (pwm_ff[a] >= pwm_period_ff) begin
                     pwm_in[a]    = '0;
                     pulses_in[a] = pulses_ff[a] - 1'b1;
                  end else begin
                     pwm_in[a] = pwm_ff[a] + 1'b1;
                  end
               end else begin
                  presc_in[a] = presc_ff[a] + 1'b1;
               end
            end
         end
         if (busy_before && (pulses_in[AXIS_HOR] == '0) && (pulses_in[AXIS_VER] == '0)) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               position_in[a] = goal_ff[a];
            end
            done_in = 1'b1;
         end
      end else if (!busy_before) begin
         accepted_in = 1'b1;
         if (in_dead[AXIS_HOR] && in_dead[AXIS_VER]) begin
            done_in = 1'b1;
         end else begin
            for (int a = 0; a < NUM_AXES; a++) begin
               dir_in[a]  = ~delta[a][32];
               goal_in[a] = target[a];
               if (move_cnt[a] != '0) begin
                  pulses_in[a] = move_cnt[a];
                  presc_in[a]  = '0;
                  pwm_in[a]    = '0;
               end
            end
            if ((move_cnt[AXIS_HOR] == '0) && (move_cnt[AXIS_VER] == '0)) begin
               for (int a = 0; a < NUM_AXES; a++) begin
                  position_in[a] = target[a];
               end
               done_in = 1'b1;
            end
         end
      end
      busy_after = (pulses_in[AXIS_HOR] != '0) || (pulses_in[AXIS_VER] != '0);
      for (int a = 0; a < NUM_AXES; a++) begin
         step_now[a]  = (pulses_ff[a] != '0) && (pwm_ff[a] < pwm_compare_ff);
         step_next[a] = (pulses_in[a] != '0) && (pwm_in[a] < pwm_compare_ff);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_limit_ff <= PRESCALE_LIMIT_RST;
         pwm_period_ff     <= PWM_PERIOD_RST;
         pwm_compare_ff    <= PWM_COMPARE_RST;
         steps_per_unit_ff <= STEPS_PER_UNIT_RST;
         dead_band_ff      <= DEAD_BAND_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRESCALE_LIMIT: prescale_limit_ff <= csr_wdata[CNT16_WIDTH-1:0];
            CSR_PWM_PERIOD:     pwm_period_ff     <= csr_wdata[CNT16_WIDTH-1:0];
            CSR_PWM_COMPARE:    pwm_compare_ff    <= csr_wdata[CNT16_WIDTH-1:0];
            CSR_STEPS_PER_UNIT: steps_per_unit_ff <= csr_wdata[SPU_WIDTH-1:0];
            CSR_DEAD_BAND:      dead_band_ff      <= csr_wdata[CNT16_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // axis state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            position_ff[a] <= '0;
            goal_ff[a]     <= '0;
            presc_ff[a]    <= '0;
            pwm_ff[a]      <= '0;
            pulses_ff[a]   <= '0;
            dir_ff[a]      <= 1'b0;
         end
      end else if (req_accept) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            position_ff[a] <= position_in[a];
            goal_ff[a]     <= goal_in[a];
            presc_ff[a]    <= presc_in[a];
            pwm_ff[a]      <= pwm_in[a];
            pulses_ff[a]   <= pulses_in[a];
            dir_ff[a]      <= dir_in[a];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_hor_step_ff      <= (req_op == OP_TICK) ? step_now[AXIS_HOR] : step_next[AXIS_HOR];
         rsp_ver_step_ff      <= (req_op == OP_TICK) ? step_now[AXIS_VER] : step_next[AXIS_VER];
         rsp_hor_dir_ff       <= dir_in[AXIS_HOR];
         rsp_ver_dir_ff       <= dir_in[AXIS_VER];
         rsp_busy_res_ff      <= busy_after;
         rsp_move_accepted_ff <= accepted_in;
         rsp_move_done_ff     <= done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hor_step      = rsp_hor_step_ff;
   assign rsp_ver_step      = rsp_ver_step_ff;
   assign rsp_hor_dir       = rsp_hor_dir_ff;
   assign rsp_ver_dir       = rsp_ver_dir_ff;
   assign rsp_busy_res      = rsp_busy_res_ff;
   assign rsp_move_accepted = rsp_move_accepted_ff;
   assign rsp_move_done     = rsp_move_done_ff;

   // a move that arrives while an axis still has pulses is refused
   a_refuse_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_MOVE) && busy_before) |=> !rsp_move_accepted_ff)
      else $error("move accepted while busy");

   // a tick never reports an accepted move
   a_tick_no_accept: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_TICK)) |=> !rsp_move_accepted_ff)
      else $error("tick reported as accepted move");

   // completed move leaves both axes idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_move_done_ff) |-> !rsp_busy_res_ff)
      else $error("move done while still busy");

   // idle tick drives no step pulses
   a_idle_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_TICK) && !busy_before)
      |=> (!rsp_hor_step_ff && !rsp_ver_step_ff && !rsp_move_done_ff))
      else $error("step or done on idle tick");

   // pulse counts stay within the saturation limit
   a_pulse_cap: assert property (@(posedge clock) disable iff (reset)
      ({{(64-PW){1'b0}}, pulses_ff[AXIS_HOR]} <= PULSE_CAP)
      && ({{(64-PW){1'b0}}, pulses_ff[AXIS_VER]} <= PULSE_CAP))
      else $error("pulse count above limit");

endmodule

/* bench/step_dir_checker.sv */
`timescale 1ns / 1ps

module step_dir_checker
   import stepgen_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DFLT
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_op,
   input  logic signed [POS_WIDTH-1:0] req_hor_target,
   input  logic signed [POS_WIDTH-1:0] req_ver_target,

   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_hor_step,
   input  logic                        rsp_ver_step,
   input  logic                        rsp_hor_dir,
   input  logic                        rsp_ver_dir,
   input  logic                        rsp_busy_res,
   input  logic                        rsp_move_accepted,
   input  logic                        rsp_move_done,

   input  logic                        csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_wdata,

   output int                          failures,
   output int                          outstanding
);

   typedef struct {
      pos_type              position;
      pos_type              goal;
      cnt16_type            prescale_count;
      cnt16_type            pwm_count;
      logic [COUNT_WIDTH:0] pulses_left;
      logic                 direction;
   } axis_state_type;

   typedef struct packed {
      logic hor_step;
      logic ver_step;
      logic hor_dir;
      logic ver_dir;
      logic busy;
      logic accepted;
      logic done;
   } step_outputs_type;

   localparam int NUM_FIELDS = 7;

   string field_names [NUM_FIELDS] = '{"hor_step", "ver_step", "hor_dir", "ver_dir",
                                       "busy_res", "move_accepted", "move_done"};

   cnt16_type               prescale_limit;
   cnt16_type               pwm_period;
   cnt16_type               pwm_compare;
   logic [SPU_WIDTH-1:0]    steps_per_unit;
   cnt16_type               dead_band;

   axis_state_type          hor_axis;
   axis_state_type          ver_axis;
   step_outputs_type        pending_outputs [$];

   function automatic logic step_level(axis_state_type a);
      return (a.pulses_left != 0) && (a.pwm_count < pwm_compare);
   endfunction

   function automatic axis_state_type advance_axis(axis_state_type a);
      if (a.pulses_left != 0) begin
         if (a.prescale_count >= prescale_limit) begin
            a.prescale_count = '0;
            if (a.pwm_count >= pwm_period) begin
               a.pwm_count = '0;
               a.pulses_left = a.pulses_left - 1'b1;
            end else begin
               a.pwm_count = a.pwm_count + 1'b1;
            end
         end else begin
            a.prescale_count = a.prescale_count + 1'b1;
         end
      end
      return a;
   endfunction

   // floor(|distance| * steps_per_unit / 2^32), saturated at 2^COUNT_WIDTH, zero below dead_band
   function automatic logic [COUNT_WIDTH:0] pulses_for(longint unsigned mag);
      longint unsigned prod;
      longint unsigned cnt;
      longint unsigned cap;
      cap = 64'd1 << COUNT_WIDTH;
      if (mag < dead_band)
         return '0;
      prod = mag * steps_per_unit;
      cnt = prod >> 32;
      if (cnt > cap)
         cnt = cap;
      return cnt[COUNT_WIDTH:0];
   endfunction

   function automatic step_outputs_type next_step_outputs(logic op, pos_type ht,
                                                          pos_type vt);
      step_outputs_type     r;
      logic                 busy_before;
      longint               hd;
      longint               vd;
      longint unsigned      hm;
      longint unsigned      vm;
      logic [COUNT_WIDTH:0] hp;
      logic [COUNT_WIDTH:0] vp;
      r = '0;
      busy_before = (hor_axis.pulses_left != 0) || (ver_axis.pulses_left != 0);
      if (op == OP_TICK) begin
         r.hor_step = step_level(hor_axis);
         r.ver_step = step_level(ver_axis);
         hor_axis = advance_axis(hor_axis);
         ver_axis = advance_axis(ver_axis);
         if (busy_before && hor_axis.pulses_left == 0 && ver_axis.pulses_left == 0) begin
            hor_axis.position = hor_axis.goal;
            ver_axis.position = ver_axis.goal;
            r.done = 1'b1;
         end
      end else begin
         if (!busy_before) begin
            hd = longint'($signed(ht)) - longint'($signed(hor_axis.position));
            vd = longint'($signed(vt)) - longint'($signed(ver_axis.position));
            hm = (hd < 0) ? -hd : hd;
            vm = (vd < 0) ? -vd : vd;
            r.accepted = 1'b1;
            if (hm < dead_band && vm < dead_band) begin
               r.done = 1'b1;
            end else begin
               hp = pulses_for(hm);
               vp = pulses_for(vm);
               hor_axis.direction = (hd >= 0);
               ver_axis.direction = (vd >= 0);
               hor_axis.goal = ht;
               ver_axis.goal = vt;
               if (hp != 0) begin
                  hor_axis.pulses_left = hp;
                  hor_axis.prescale_count = '0;
                  hor_axis.pwm_count = '0;
               end
               if (vp != 0) begin
                  ver_axis.pulses_left = vp;
                  ver_axis.prescale_count = '0;
                  ver_axis.pwm_count = '0;
               end
               if (hp == 0 && vp == 0) begin
                  hor_axis.position = hor_axis.goal;
                  ver_axis.position = ver_axis.goal;
                  r.done = 1'b1;
               end
            end
         end
         r.hor_step = step_level(hor_axis);
         r.ver_step = step_level(ver_axis);
      end
      r.hor_dir = hor_axis.direction;
      r.ver_dir = ver_axis.direction;
      r.busy = (hor_axis.pulses_left != 0) || (ver_axis.pulses_left != 0);
      return r;
   endfunction

   always @(posedge clock) begin
      step_outputs_type want;
      step_outputs_type got;
      logic             wrong;
      if (reset) begin
         prescale_limit = PRESCALE_LIMIT_RST;
         pwm_period = PWM_PERIOD_RST;
         pwm_compare = PWM_COMPARE_RST;
         steps_per_unit = STEPS_PER_UNIT_RST;
         dead_band = DEAD_BAND_RST;
         hor_axis = '{default: '0};
         ver_axis = '{default: '0};
         pending_outputs.delete();
         failures <= 0;
      end else begin
         // a result leaving now belongs to an earlier transaction
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_hor_step, rsp_ver_step, rsp_hor_dir, rsp_ver_dir,
                   rsp_busy_res, rsp_move_accepted, rsp_move_done};
            if (pending_outputs.size() == 0) begin
               $display("%0t: result with nothing outstanding, expected none actual %b",
                        $time, got);
               failures <= failures + 1;
            end else begin
               want = pending_outputs.pop_front();
               wrong = 1'b0;
               for (int i = 0; i < NUM_FIELDS; i++) begin
                  if (want[NUM_FIELDS-1-i] !== got[NUM_FIELDS-1-i]) begin
                     $display("%0t: %s expected %0d actual %0d", $time, field_names[i],
                              want[NUM_FIELDS-1-i], got[NUM_FIELDS-1-i]);
                     wrong = 1'b1;
                  end
               end
               if (wrong)
                  failures <= failures + 1;
            end
         end
         if (req_valid && !req_stall)
            pending_outputs.push_back(next_step_outputs(req_op, req_hor_target,
                                                        req_ver_target));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PRESCALE_LIMIT: prescale_limit = csr_wdata[CNT16_WIDTH-1:0];
               CSR_PWM_PERIOD:     pwm_period = csr_wdata[CNT16_WIDTH-1:0];
               CSR_PWM_COMPARE:    pwm_compare = csr_wdata[CNT16_WIDTH-1:0];
               CSR_STEPS_PER_UNIT: steps_per_unit = csr_wdata[SPU_WIDTH-1:0];
               CSR_DEAD_BAND:      dead_band = csr_wdata[CNT16_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= pending_outputs.size();
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import stepgen_pkg::*;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_op = OP_TICK;
   logic signed [POS_WIDTH-1:0] req_hor_target = '0;
   logic signed [POS_WIDTH-1:0] req_ver_target = '0;

   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_hor_step;
   logic                        rsp_ver_step;
   logic                        rsp_hor_dir;
   logic                        rsp_ver_dir;
   logic                        rsp_busy_res;
   logic                        rsp_move_accepted;
   logic                        rsp_move_done;

   logic                        csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata = '0;

   int                          failures;
   int                          outstanding;
   int                          src_idle_pct = 0;
   int                          sink_stall_pct = 0;

   always #10 clock = ~clock;

   two_axis_step_dir_pulse_generator dut (.*);

   step_dir_checker checker_i (.*);

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);

   task automatic send_item(input logic op, input pos_type hor_t, input pos_type ver_t);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_hor_target <= hor_t;
      req_ver_target <= ver_t;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_regs(input int unsigned pre, input int unsigned per,
                             input int unsigned cmp, input int unsigned spu,
                             input int unsigned db);
      write_reg(CSR_PRESCALE_LIMIT, pre);
      write_reg(CSR_PWM_PERIOD, per);
      write_reg(CSR_PWM_COMPARE, cmp);
      write_reg(CSR_STEPS_PER_UNIT, spu);
      write_reg(CSR_DEAD_BAND, db);
   endtask

   // stop sending and let every outstanding transaction come back
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   function automatic pos_type pick_target(int span, bit full_range);
      if (full_range)
         return $urandom;
      return pos_type'(int'($urandom_range(2 * span)) - span);
   endfunction

   task automatic run_phase(input int unsigned pre, input int unsigned per,
                            input int unsigned cmp, input int unsigned spu,
                            input int unsigned db, input int span, input bit full_range,
                            input int items, input int burst,
                            input int src_pct, input int sink_pct);
      int sent;
      int ticks;
      wait_quiet();
      write_regs(pre, per, cmp, spu, db);
      src_idle_pct = src_pct;
      sink_stall_pct = sink_pct;
      sent = 0;
      while (sent < items) begin
         send_item(OP_MOVE, pick_target(span, full_range), pick_target(span, full_range));
         sent++;
         // back-to-back move, mostly refused
         if ($urandom_range(5) == 0) begin
            send_item(OP_MOVE, pick_target(span, full_range),
                      pick_target(span, full_range));
            sent++;
         end
         ticks = $urandom_range(burst);
         repeat (ticks)
            send_item(OP_TICK, $urandom, $urandom);
         sent += ticks;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: idle tick, dead band, zero-pulse move, busy refusal
      send_item(OP_TICK, '0, '0);
      send_item(OP_MOVE, 32'sd0, 32'sd0);
      send_item(OP_MOVE, 32'sd65, -32'sd65);
      send_item(OP_MOVE, 32'sh0000_8000, 32'sd0);
      send_item(OP_MOVE, 32'sd0, -32'sh0001_0000);
      send_item(OP_MOVE, 32'sh0010_0000, 32'sd0);
      repeat (3) send_item(OP_TICK, '1, '1);

      // period lowered below a running pwm counter, then target extremes
      wait_quiet();
      write_regs(0, 1, 1, 0, 0);
      repeat (4) send_item(OP_TICK, '0, '1);
      send_item(OP_MOVE, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(OP_MOVE, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(OP_MOVE, 32'hFFFF_FFFF, 32'h0000_0001);
      send_item(OP_MOVE, 32'h0000_0000, 32'h0000_0000);
      repeat (2) send_item(OP_TICK, '1, '0);

      run_phase(0, 2, 1, 32'h0001_0000, 66, 32'h0004_0000, 0, 250, 40, 0, 0);
      run_phase(1, 3, 2, 32'h0002_0000, 0, 32'h0003_0000, 0, 200, 120, 56, 0);
      run_phase(0, 0, 0, 32'h0001_0000, 65535, 32'h0004_0000, 0, 180, 15, 0, 56);
      run_phase(0, 2, 1, 0, 0, 0, 1, 150, 5, 6, 6);
      run_phase(0, 1, 1, 3, 65535, 0, 1, 200, 8, 0, 0);
      run_phase(0, 1, 65535, 0, 0, 16, 0, 80, 4, 56, 0);
      run_phase(0, 1, 65535, 32'hFFFF_FFFF, 8, 16, 0, 200, 80, 0, 56);
      // long prescale and long period leave axes mid-move for the next phase
      run_phase(65535, 0, 1, 32'h0001_0000, 66, 32'h0002_0000, 0, 120, 30, 6, 6);
      run_phase(0, 65535, 1000, 32'h0001_0000, 66, 32'h0002_0000, 0, 120, 30, 0, 0);
      run_phase(0, 1, 1, 32'h0001_0000, 66, 32'h0004_0000, 0, 300, 40, 56, 0);

      @(negedge clock);
      req_valid <= 1'b0;
      src_idle_pct = 0;
      sink_stall_pct = 0;
      for (int n = 0; n < 2000 && outstanding != 0; n++)
         @(negedge clock);
      repeat (4) @(negedge clock);
      if (failures == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* two_axis_step_dir_pulse_generator.f */
hw/rtl/stepgen_pkg.sv
hw/rtl/two_axis_step_dir_pulse_generator.sv
bench/step_dir_checker.sv
bench/tb_top.sv
